@@ rtl/sbf_pkg.sv @@
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types, constants and small functions of the scan to point box filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbf_pkg;

    // Largest number of z copies emitted for one beam.
    localparam int MAX_REPEATS = 16;
    // Resolution of the phase that feeds the sine evaluation.
    localparam int ANGLE_BITS  = 16;

    // Low angle bits that are dropped when the phase is coarser than 16 bits.
    localparam int ANGLE_DROP = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
    localparam logic [13:0] FRAC_MASK = 14'(14'h3FFF << ANGLE_DROP);

    // Copy counter width: holds the repeat register and MAX_REPEATS.
    localparam int REP_W = $clog2(MAX_REPEATS + 1);
    localparam int CNT_W = (REP_W > 5) ? REP_W : 5;

    // One in Q30.
    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

    // Sequencer step count for the trig and projection phase.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] TRIG_LAST = 5'd19;

    // Configuration register indexes.
    localparam logic [2:0] REG_BOX_MIN_X    = 3'd0;
    localparam logic [2:0] REG_BOX_MAX_X    = 3'd1;
    localparam logic [2:0] REG_BOX_MIN_Y    = 3'd2;
    localparam logic [2:0] REG_BOX_MAX_Y    = 3'd3;
    localparam logic [2:0] REG_REPEAT_COUNT = 3'd4;
    localparam logic [2:0] REG_HEIGHT_STEP  = 3'd5;
    localparam logic [2:0] REG_ANGLE_START  = 3'd6;
    localparam logic [2:0] REG_ANGLE_STEP   = 3'd7;

    // Operation of the shared multiplier, also selecting how its product is used.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ANGLE,
        OP_SQ_S,
        OP_SQ_C,
        OP_HORN_S,
        OP_HORN_C,
        OP_FIN_S,
        OP_FIN_C,
        OP_X,
        OP_Y
    } mul_op_t;

    typedef struct packed {
        logic signed [15:0] box_min_x;
        logic signed [15:0] box_max_x;
        logic signed [15:0] box_min_y;
        logic signed [15:0] box_max_y;
        logic [4:0]         repeat_count;
        logic [11:0]        height_step;
        logic [15:0]        angle_start;
        logic [15:0]        angle_step;
    } sbf_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        mul_op_t    op;
        logic [2:0] coef;
        logic       emit_init;
        logic       emit_adv;
    } sbf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pass;
        logic last;
    } sbf_status_t;

    // Q30 coefficients of the odd sine series in powers of u^2.
    function automatic logic signed [31:0] sin_coef(input logic [2:0] idx);
        logic signed [31:0] c;
        unique case (idx)
            3'd0:    c = 32'sd1686629713;
            3'd1:    c = -32'sd693598668;
            3'd2:    c = 32'sd85569306;
            3'd3:    c = -32'sd5026995;
            3'd4:    c = 32'sd172272;
            3'd5:    c = -32'sd3864;
            default: c = 32'sd0;
        endcase
        return c;
    endfunction

    // Multiplier operation issued at each sequencer step.
    function automatic mul_op_t step_op(input logic [STEP_W-1:0] step);
        mul_op_t op;
        priority if (step == 5'd0)
            op = OP_ANGLE;
        else if (step == 5'd2)
            op = OP_SQ_S;
        else if (step == 5'd3)
            op = OP_SQ_C;
        else if (step >= 5'd4 && step <= 5'd13)
            op = step[0] ? OP_HORN_C : OP_HORN_S;
        else if (step == 5'd14)
            op = OP_FIN_S;
        else if (step == 5'd15)
            op = OP_FIN_C;
        else if (step == 5'd17)
            op = OP_X;
        else if (step == 5'd18)
            op = OP_Y;
        else
            op = OP_NONE;
        return op;
    endfunction

    // Horner coefficient for a series step: sine and cosine steps alternate.
    function automatic logic [2:0] step_coef(input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] d;
        d = step - 5'd4;
        return 3'd4 - d[3:1];
    endfunction

endpackage

`default_nettype wire

@@ rtl/sbf_regs.sv @@
// ----------------------------------------------------------------------------
// sbf_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_regs
    import sbf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output sbf_cfg_t         cfg
);

    sbf_cfg_t cfg_reg;
    sbf_cfg_t cfg_next;

    // Decode the write into the addressed register.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOX_MIN_X:    cfg_next.box_min_x    = cfg_data;
                REG_BOX_MAX_X:    cfg_next.box_max_x    = cfg_data;
                REG_BOX_MIN_Y:    cfg_next.box_min_y    = cfg_data;
                REG_BOX_MAX_Y:    cfg_next.box_max_y    = cfg_data;
                REG_REPEAT_COUNT: cfg_next.repeat_count = cfg_data[4:0];
                REG_HEIGHT_STEP:  cfg_next.height_step  = cfg_data[11:0];
                REG_ANGLE_START:  cfg_next.angle_start  = cfg_data;
                REG_ANGLE_STEP:   cfg_next.angle_step   = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_min_x    <= -16'sd2000;
            cfg_reg.box_max_x    <= 16'sd2000;
            cfg_reg.box_min_y    <= -16'sd2000;
            cfg_reg.box_max_y    <= 16'sd2000;
            cfg_reg.repeat_count <= 5'd10;
            cfg_reg.height_step  <= 12'd100;
            cfg_reg.angle_start  <= 16'd0;
            cfg_reg.angle_step   <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/sbf_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbf_ctrl
// Controller: takes a beam, steps the datapath through the trig series and
// the projection, checks the box and hands out the z copies.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_ctrl
    import sbf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        beam_valid,
    input  wire logic        range_valid,
    input  wire logic        point_stall,
    input  wire sbf_status_t status,
    output sbf_cmd_t         cmd,
    output logic             beam_stall,
    output logic             point_valid
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_TRIG  = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    // Next state and command decode.
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd.accept    = 1'b0;
        cmd.op        = OP_NONE;
        cmd.coef      = 3'd0;
        cmd.emit_init = 1'b0;
        cmd.emit_adv  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = beam_valid;
                step_next  = '0;
                // An invalid beam only advances the beam counter.
                if (beam_valid && range_valid)
                    state_next = ST_TRIG;
            end
            ST_TRIG:
            begin
                cmd.op    = step_op(step_reg);
                cmd.coef  = step_coef(step_reg);
                step_next = step_reg + 5'd1;
                if (step_reg == TRIG_LAST)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.emit_init = 1'b1;
                state_next    = status.pass ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!point_stall)
                begin
                    cmd.emit_adv = 1'b1;
                    if (status.last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign beam_stall  = (state_reg != ST_IDLE);
    assign point_valid = (state_reg == ST_EMIT);

endmodule

`default_nettype wire

@@ rtl/sbf_dp.sv @@
// ----------------------------------------------------------------------------
// sbf_dp
// Datapath: beam counter, one shared 32x32 multiplier with a registered
// product, sine/cosine series registers, point registers and copy counter.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_dp
    import sbf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire sbf_cfg_t     cfg,
    input  wire sbf_cmd_t     cmd,
    input  wire logic [15:0]  range_mm,
    input  wire logic         scan_start,
    output sbf_status_t       status,
    output logic signed [16:0] point_x,
    output logic signed [16:0] point_y,
    output logic [15:0]       point_z,
    output logic              last_point
);

    // Beam counter and the latched beam.
    logic [15:0]        beam_cnt_reg;
    logic [15:0]        cur_cnt_reg;
    logic [15:0]        range_reg;
    logic [15:0]        cnt_used;

    // Multiplier pipeline.
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod_next;
    logic signed [63:0] prod_reg;
    mul_op_t            op_q_reg;
    logic [2:0]         coef_q_reg;

    // Series state.
    logic [1:0]         quad_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] v;
    logic signed [31:0] u2s_reg;
    logic signed [31:0] u2c_reg;
    logic signed [31:0] ps_reg;
    logic signed [31:0] pc_reg;
    logic [14:0]        s_reg;
    logic [14:0]        c_reg;
    logic signed [15:0] sn;
    logic signed [15:0] cs;

    // Product post-processing.
    logic signed [63:0] shr30;
    logic [15:0]        angle;
    logic signed [31:0] xy_rnd;

    // Point and copy state.
    logic signed [16:0] x_reg;
    logic signed [16:0] y_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [15:0]        z_reg;
    logic [CNT_W-1:0]   rep_ext;
    logic [CNT_W-1:0]   n_copies;
    logic signed [16:0] min_x;
    logic signed [16:0] max_x;
    logic signed [16:0] min_y;
    logic signed [16:0] max_y;
    logic               in_box;

    // Round a Q30 value to Q1.15 and clamp it to [0, 32767].
    function automatic logic [14:0] round_q15(input logic signed [33:0] q30);
        logic signed [33:0] t;
        logic signed [33:0] r;
        logic [14:0]        res;
        t = q30 + 34'sd16384;
        r = t >>> 15;
        if (r > 34'sd32767)
            res = 15'h7FFF;
        else if (r < 34'sd0)
            res = 15'd0;
        else
            res = r[14:0];
        return res;
    endfunction

    // Beam counter: a start-of-scan beam uses zero, every beam advances it.
    assign cnt_used = scan_start ? 16'd0 : beam_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beam_cnt_reg <= 16'd0;
        else if (cmd.accept)
            beam_cnt_reg <= cnt_used + 16'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_cnt_reg <= cnt_used;
            range_reg   <= range_mm;
        end
    end

    // Cosine argument and quadrant sign mapping.
    assign v = Q30_ONE - u_reg;

    always_comb
    begin
        unique case (quad_reg)
            2'd0:
            begin
                sn = $signed({1'b0, s_reg});
                cs = $signed({1'b0, c_reg});
            end
            2'd1:
            begin
                sn = $signed({1'b0, c_reg});
                cs = -$signed({1'b0, s_reg});
            end
            2'd2:
            begin
                sn = -$signed({1'b0, s_reg});
                cs = -$signed({1'b0, c_reg});
            end
            2'd3:
            begin
                sn = -$signed({1'b0, c_reg});
                cs = $signed({1'b0, s_reg});
            end
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (cmd.op)
            OP_ANGLE:
            begin
                mul_a = $signed({16'd0, cur_cnt_reg});
                mul_b = $signed({16'd0, cfg.angle_step});
            end
            OP_SQ_S:
            begin
                mul_a = u_reg;
                mul_b = u_reg;
            end
            OP_SQ_C:
            begin
                mul_a = v;
                mul_b = v;
            end
            OP_HORN_S:
            begin
                mul_a = ps_reg;
                mul_b = u2s_reg;
            end
            OP_HORN_C:
            begin
                mul_a = pc_reg;
                mul_b = u2c_reg;
            end
            OP_FIN_S:
            begin
                mul_a = ps_reg;
                mul_b = u_reg;
            end
            OP_FIN_C:
            begin
                mul_a = pc_reg;
                mul_b = v;
            end
            OP_X:
            begin
                mul_a = $signed({16'd0, range_reg});
                mul_b = 32'(cs);
            end
            OP_Y:
            begin
                mul_a = $signed({16'd0, range_reg});
                mul_b = 32'(sn);
            end
            default:
            begin
                mul_a = 32'sd0;
                mul_b = 32'sd0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // The operation travels with its product so it is consumed in the cycle after the product is formed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_q_reg   <= OP_NONE;
            coef_q_reg <= 3'd0;
        end
        else
        begin
            op_q_reg   <= cmd.op;
            coef_q_reg <= cmd.coef;
        end
    end

    assign shr30  = prod_reg >>> 30;
    assign angle  = cfg.angle_start + prod_reg[15:0];
    assign xy_rnd = prod_reg[31:0] + 32'sd16384;

    // Product register and consumption of the previous product.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        unique case (op_q_reg)
            OP_ANGLE:
            begin
                quad_reg <= angle[15:14];
                u_reg    <= $signed({2'b00, angle[13:0] & FRAC_MASK, 16'd0});
            end
            OP_SQ_S:
            begin
                u2s_reg <= shr30[31:0];
                ps_reg  <= sin_coef(3'd5);
            end
            OP_SQ_C:
            begin
                u2c_reg <= shr30[31:0];
                pc_reg  <= sin_coef(3'd5);
            end
            OP_HORN_S: ps_reg <= sin_coef(coef_q_reg) + shr30[31:0];
            OP_HORN_C: pc_reg <= sin_coef(coef_q_reg) + shr30[31:0];
            OP_FIN_S:  s_reg  <= round_q15(shr30[33:0]);
            OP_FIN_C:  c_reg  <= round_q15(shr30[33:0]);
            OP_X:      x_reg  <= xy_rnd[31:15];
            OP_Y:      y_reg  <= xy_rnd[31:15];
            default:
            begin
            end
        endcase
    end

    // Box test with inclusive limits and saturated copy count.
    assign min_x = $signed({cfg.box_min_x[15], cfg.box_min_x});
    assign max_x = $signed({cfg.box_max_x[15], cfg.box_max_x});
    assign min_y = $signed({cfg.box_min_y[15], cfg.box_min_y});
    assign max_y = $signed({cfg.box_max_y[15], cfg.box_max_y});
    assign in_box = (x_reg >= min_x) && (x_reg <= max_x) &&
                    (y_reg >= min_y) && (y_reg <= max_y);

    assign rep_ext  = CNT_W'(cfg.repeat_count);
    assign n_copies = (rep_ext > CNT_W'(MAX_REPEATS)) ? CNT_W'(MAX_REPEATS) : rep_ext;

    assign status.pass = in_box && (n_copies != '0);
    assign status.last = (k_reg == (n_copies - CNT_W'(1)));

    // Copy index and z accumulator; z wraps at 16 bits.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_init)
        begin
            k_reg <= '0;
            z_reg <= 16'd0;
        end
        else if (cmd.emit_adv)
        begin
            k_reg <= k_reg + CNT_W'(1);
            z_reg <= z_reg + {4'd0, cfg.height_step};
        end
    end

    assign point_x    = x_reg;
    assign point_y    = y_reg;
    assign point_z    = z_reg;
    assign last_point = status.last;

endmodule

`default_nettype wire

@@ rtl/scan_to_point_box_filter.sv @@
// ----------------------------------------------------------------------------
// scan_to_point_box_filter
// Converts laser beams (range, angle from a beam counter) to x/y points in
// millimetres, drops beams outside the x/y box and emits repeated z copies.
// A beam is taken only while the block is idle. A valid beam is first accepted,
// then a single shared 32x32 multiplier works out the beam angle, the Q30
// sine and cosine series (interleaved, one product per cycle) and x and y,
// and the box is tested; a beam in the box then puts out one point per cycle
// while point_stall is low. An invalid beam only advances the beam counter.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_to_point_box_filter
    import sbf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         beam_valid,
    output logic              beam_stall,
    input  wire logic [15:0]  range_mm,
    input  wire logic         range_valid,
    input  wire logic         scan_start,
    output logic              point_valid,
    input  wire logic         point_stall,
    output logic signed [16:0] point_x,
    output logic signed [16:0] point_y,
    output logic [15:0]       point_z,
    output logic              last_point
);

    sbf_cfg_t    cfg;
    sbf_cmd_t    cmd;
    sbf_status_t status;

    // Configuration registers.
    sbf_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer.
    sbf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .beam_valid  (beam_valid),
        .range_valid (range_valid),
        .point_stall (point_stall),
        .status      (status),
        .cmd         (cmd),
        .beam_stall  (beam_stall),
        .point_valid (point_valid)
    );

    // Arithmetic and point registers.
    sbf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .range_mm   (range_mm),
        .scan_start (scan_start),
        .status     (status),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .last_point (last_point)
    );

endmodule

`default_nettype wire

@@ rtl/sbf_checker.sv @@
// ----------------------------------------------------------------------------
// sbf_checker
// Port-level checks of the scan to point box filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        beam_valid,
    input wire logic        beam_stall,
    input wire logic        range_valid,
    input wire logic        point_valid,
    input wire logic        point_stall,
    input wire logic [16:0] point_x,
    input wire logic [16:0] point_y,
    input wire logic        last_point
);

    // A valid beam keeps the block busy on the next cycle.
    a_valid_beam_busy: assert property (@(posedge clk) disable iff (!rst_n)
        beam_valid && !beam_stall && range_valid |=> beam_stall)
        else $error("valid beam did not start processing");

    // An invalid beam leaves the input side open.
    a_invalid_beam_idle: assert property (@(posedge clk) disable iff (!rst_n)
        beam_valid && !beam_stall && !range_valid |=> !beam_stall)
        else $error("invalid beam blocked the input");

    // No new beam is taken while points are being handed out.
    a_one_beam: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> beam_stall)
        else $error("input open while points pending");

    // The beat marked last ends the burst.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall && last_point |=> !point_valid)
        else $error("point after last beat");

    // Copies of one beam follow back to back with the same x and y.
    a_same_xy: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall && !last_point |=>
            point_valid && $stable(point_x) && $stable(point_y))
        else $error("copy burst broken or x/y changed");

endmodule

bind scan_to_point_box_filter sbf_checker u_sbf_checker (.*);

`default_nettype wire
